// ----- rtl/core/slmcc_pkg.sv -----
// Shared widths and constants for the stereo level meter with copy check.
`default_nettype none

package slmcc_pkg;

    localparam int IN_W   = 16;  // input sample port width
    localparam int SQ_W   = 53;  // square sum accumulator and output
    localparam int ACC_W  = 40;  // signed sample accumulator
    localparam int SUM_W  = 39;  // signed sum output
    localparam int PEAK_W = 16;  // peak output
    localparam int CNT_W  = 23;  // frame and equal-frame counters

    localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = 23'd40000;

endpackage

`default_nettype wire

// ----- rtl/core/stereo_level_meter_copy_check.sv -----
// Top level of the stereo level meter with copy check.
// Takes one stereo frame per cycle and, after frame_count frames (zero acts
// as one), emits per channel the sum of squares, the signed sum and the peak
// magnitude plus the number of frames with equal left and right samples,
// then starts the next measurement from zero. Only the low SAMPLE_BITS bits
// of each sample port are used, sign-extended. The frame that completes the
// measurement passes the input register, which loads at acceptance, then the
// square register, then accumulators and output register, where its result
// is registered. The input stalls only while a result waits at a
// stalled output and the frame at the accumulators would complete the next
// measurement.
`default_nettype none

module stereo_level_meter_copy_check #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [slmcc_pkg::CNT_W-1:0]         i_cfg_data,
    // frame requests
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [slmcc_pkg::IN_W-1:0]   i_left_sample,
    input  wire logic signed [slmcc_pkg::IN_W-1:0]   i_right_sample,
    // result requests
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [slmcc_pkg::SQ_W-1:0]               o_left_square_sum,
    output logic [slmcc_pkg::SQ_W-1:0]               o_right_square_sum,
    output logic signed [slmcc_pkg::SUM_W-1:0]       o_left_sum,
    output logic signed [slmcc_pkg::SUM_W-1:0]       o_right_sum,
    output logic [slmcc_pkg::PEAK_W-1:0]             o_left_peak,
    output logic [slmcc_pkg::PEAK_W-1:0]             o_right_peak,
    output logic [slmcc_pkg::CNT_W-1:0]              o_equal_count
);

    localparam int SB    = SAMPLE_BITS;
    localparam int RAW_W = (SB > slmcc_pkg::IN_W) ? SB : slmcc_pkg::IN_W;
    localparam int SQP_W = 2 * SB;

    // configuration register
    logic [slmcc_pkg::CNT_W-1:0] r_frame_count;

    // stage 1: input register
    logic                 r_v1;
    logic signed [SB-1:0] r_l1, r_r1;

    // stage 2: magnitude and square register
    logic                 r_v2;
    logic signed [SB-1:0] r_l2, r_r2;
    logic [SB-1:0]        r_lmag2, r_rmag2;
    logic [SQP_W-1:0]     r_lsq2, r_rsq2;
    logic                 r_eq2;

    // accumulators
    logic [slmcc_pkg::SQ_W-1:0]  r_lsq_acc, r_rsq_acc;
    logic [slmcc_pkg::ACC_W-1:0] r_lacc, r_racc;
    logic [SB-1:0]               r_lmax, r_rmax;
    logic [slmcc_pkg::CNT_W-1:0] r_same, r_frames;

    // output register
    logic r_ov;

    // input sign extension
    logic [slmcc_pkg::IN_W-1:0] l_bits, r_bits;
    logic [RAW_W-1:0]           l_raw, r_raw;
    logic signed [SB-1:0]       l_in, r_in;

    // stage 2 logic
    logic [SB-1:0]    l_mag, r_mag;

    // accumulate logic
    logic [slmcc_pkg::SQ_W-1:0]  n_lsq_acc, n_rsq_acc;
    logic [slmcc_pkg::ACC_W-1:0] n_lacc, n_racc;
    logic [SB-1:0]               n_lmax, n_rmax;
    logic [slmcc_pkg::CNT_W-1:0] n_same, n_frames;
    logic                        done;
    logic                        en_acc, adv2, adv1;

    assign l_bits = i_left_sample;
    assign r_bits = i_right_sample;
    assign l_raw  = RAW_W'(l_bits);
    assign r_raw  = RAW_W'(r_bits);
    assign l_in   = signed'(l_raw[SB-1:0]);
    assign r_in   = signed'(r_raw[SB-1:0]);

    assign l_mag = r_l1[SB-1] ? (~r_l1 + 1'b1) : r_l1;
    assign r_mag = r_r1[SB-1] ? (~r_r1 + 1'b1) : r_r1;

    always_comb begin
        n_lsq_acc = r_lsq_acc + slmcc_pkg::SQ_W'(r_lsq2);
        n_rsq_acc = r_rsq_acc + slmcc_pkg::SQ_W'(r_rsq2);
        n_lacc    = r_lacc + slmcc_pkg::ACC_W'(r_l2);
        n_racc    = r_racc + slmcc_pkg::ACC_W'(r_r2);
        n_lmax    = (r_lmag2 > r_lmax) ? r_lmag2 : r_lmax;
        n_rmax    = (r_rmag2 > r_rmax) ? r_rmag2 : r_rmax;
        n_same    = r_same + slmcc_pkg::CNT_W'(r_eq2);
        n_frames  = r_frames + 1'b1;
        done      = (r_frame_count == '0) || (n_frames >= r_frame_count);
    end

    // hold the accumulate stage only when it would finish into a blocked output
    assign en_acc  = !(r_v2 && done && r_ov && i_stall);
    assign adv2    = !r_v2 || en_acc;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= slmcc_pkg::FRAME_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_data;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_l1 <= l_in;
            r_r1 <= r_in;
        end
        if (adv2 && r_v1) begin
            r_l2    <= r_l1;
            r_r2    <= r_r1;
            r_lmag2 <= l_mag;
            r_rmag2 <= r_mag;
            r_lsq2  <= SQP_W'(l_mag) * SQP_W'(l_mag);
            r_rsq2  <= SQP_W'(r_mag) * SQP_W'(r_mag);
            r_eq2   <= (r_l1 == r_r1);
        end
    end

    // accumulators: clear on the frame that ends a measurement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsq_acc <= '0;
            r_rsq_acc <= '0;
            r_lacc    <= '0;
            r_racc    <= '0;
            r_lmax    <= '0;
            r_rmax    <= '0;
            r_same    <= '0;
            r_frames  <= '0;
        end else if (r_v2 && en_acc) begin
            if (done) begin
                r_lsq_acc <= '0;
                r_rsq_acc <= '0;
                r_lacc    <= '0;
                r_racc    <= '0;
                r_lmax    <= '0;
                r_rmax    <= '0;
                r_same    <= '0;
                r_frames  <= '0;
            end else begin
                r_lsq_acc <= n_lsq_acc;
                r_rsq_acc <= n_rsq_acc;
                r_lacc    <= n_lacc;
                r_racc    <= n_racc;
                r_lmax    <= n_lmax;
                r_rmax    <= n_rmax;
                r_same    <= n_same;
                r_frames  <= n_frames;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_v2 && en_acc && done) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && en_acc && done) begin
            o_left_square_sum  <= n_lsq_acc;
            o_right_square_sum <= n_rsq_acc;
            o_left_sum         <= signed'(n_lacc[slmcc_pkg::SUM_W-1:0]);
            o_right_sum        <= signed'(n_racc[slmcc_pkg::SUM_W-1:0]);
            o_left_peak        <= slmcc_pkg::PEAK_W'(n_lmax);
            o_right_peak       <= slmcc_pkg::PEAK_W'(n_rmax);
            o_equal_count      <= n_same;
        end
    end

    assign o_valid = r_ov;

endmodule

`default_nettype wire

// ----- rtl/core/slmcc_checker.sv -----
// Port-level checker for the stereo level meter, bound to the top level.
`default_nettype none

module slmcc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_stall,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic [slmcc_pkg::SQ_W-1:0]         o_left_square_sum,
    input wire logic [slmcc_pkg::CNT_W-1:0]        o_equal_count
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_left_square_sum) && $stable(o_equal_count))
        else $error("result payload changed while stalled");

    // the input backs up only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // no result is raised in the cycle right after reset
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_rst_n))
        else $error("result raised right after reset");

endmodule

bind stereo_level_meter_copy_check slmcc_checker u_slmcc_checker (.*);

`default_nettype wire

// ----- test/level_meter_checker.sv -----
// Level meter checker: tracks accepted frames, predicts measurement totals, compares results.
`timescale 1ns / 1ps

module level_meter_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [slmcc_pkg::CNT_W-1:0]           i_cfg_data,
    input  logic                                  i_req_valid,
    input  logic                                  i_req_stall,
    input  logic signed [slmcc_pkg::IN_W-1:0]     i_left_sample,
    input  logic signed [slmcc_pkg::IN_W-1:0]     i_right_sample,
    input  logic                                  i_res_valid,
    input  logic                                  i_res_stall,
    input  logic [slmcc_pkg::SQ_W-1:0]            i_left_square_sum,
    input  logic [slmcc_pkg::SQ_W-1:0]            i_right_square_sum,
    input  logic signed [slmcc_pkg::SUM_W-1:0]    i_left_sum,
    input  logic signed [slmcc_pkg::SUM_W-1:0]    i_right_sum,
    input  logic [slmcc_pkg::PEAK_W-1:0]          i_left_peak,
    input  logic [slmcc_pkg::PEAK_W-1:0]          i_right_peak,
    input  logic [slmcc_pkg::CNT_W-1:0]           i_equal_count,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked
);

    typedef struct packed {
        logic [slmcc_pkg::SQ_W-1:0]   left_sq;
        logic [slmcc_pkg::SQ_W-1:0]   right_sq;
        logic [slmcc_pkg::SUM_W-1:0]  left_sum;
        logic [slmcc_pkg::SUM_W-1:0]  right_sum;
        logic [slmcc_pkg::PEAK_W-1:0] left_peak;
        logic [slmcc_pkg::PEAK_W-1:0] right_peak;
        logic [slmcc_pkg::CNT_W-1:0]  equal_cnt;
    } t_level_totals;

    logic [slmcc_pkg::CNT_W-1:0]  frame_len;
    logic [slmcc_pkg::SQ_W-1:0]   left_sq_sum, right_sq_sum;
    logic [slmcc_pkg::ACC_W-1:0]  left_total, right_total;
    logic [slmcc_pkg::PEAK_W-1:0] left_max, right_max;
    logic [slmcc_pkg::CNT_W-1:0]  same_frames, frames_in_run;

    t_level_totals totals_q[$];
    t_level_totals want;
    bit            bad;
    int            fail_cnt = 0;
    int            checked_cnt = 0;

    function automatic void clear_run();
        left_sq_sum   = '0;
        right_sq_sum  = '0;
        left_total    = '0;
        right_total   = '0;
        left_max      = '0;
        right_max     = '0;
        same_frames   = '0;
        frames_in_run = '0;
    endfunction

    function automatic void add_sample(input logic signed [slmcc_pkg::IN_W-1:0] s,
                                       inout logic [slmcc_pkg::SQ_W-1:0] sq,
                                       inout logic [slmcc_pkg::ACC_W-1:0] acc,
                                       inout logic [slmcc_pkg::PEAK_W-1:0] peak);
        longint v;
        longint mag;
        v   = s;
        mag = (v < 0) ? -v : v;
        sq  = sq + slmcc_pkg::SQ_W'(mag * mag);
        acc = acc + slmcc_pkg::ACC_W'(v);
        if (mag > longint'(peak)) begin
            peak = slmcc_pkg::PEAK_W'(mag);
        end
    endfunction

    // Fold one frame into the running measurement; queue totals when it completes.
    function automatic void measure_frame(input logic signed [slmcc_pkg::IN_W-1:0] l,
                                          input logic signed [slmcc_pkg::IN_W-1:0] r);
        t_level_totals t;
        add_sample(l, left_sq_sum, left_total, left_max);
        add_sample(r, right_sq_sum, right_total, right_max);
        if (l == r) begin
            same_frames = same_frames + 1'b1;
        end
        frames_in_run = frames_in_run + 1'b1;
        // zero length acts as one; a lowered length ends the run at the next frame
        if (frame_len != '0 && frames_in_run < frame_len) begin
            return;
        end
        t.left_sq    = left_sq_sum;
        t.right_sq   = right_sq_sum;
        t.left_sum   = left_total[slmcc_pkg::SUM_W-1:0];
        t.right_sum  = right_total[slmcc_pkg::SUM_W-1:0];
        t.left_peak  = left_max;
        t.right_peak = right_max;
        t.equal_cnt  = same_frames;
        totals_q.push_back(t);
        clear_run();
    endfunction

    function automatic bit field_differs(input string name, input longint wanted,
                                         input longint got);
        if (wanted != got) begin
            $error("%s: expected %0d, got %0d", name, wanted, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_len = slmcc_pkg::FRAME_COUNT_RESET;
            clear_run();
            totals_q.delete();
        end else begin
            if (i_cfg_we) begin
                frame_len = i_cfg_data;
            end
            if (i_res_valid && !i_res_stall) begin
                if (totals_q.size() == 0) begin
                    $error("measurement result with none expected");
                    fail_cnt++;
                end else begin
                    want = totals_q.pop_front();
                    bad = 1'b0;
                    bad |= field_differs("left_square_sum", longint'(want.left_sq),
                                         longint'(i_left_square_sum));
                    bad |= field_differs("right_square_sum", longint'(want.right_sq),
                                         longint'(i_right_square_sum));
                    bad |= field_differs("left_sum", longint'(signed'(want.left_sum)),
                                         longint'(i_left_sum));
                    bad |= field_differs("right_sum", longint'(signed'(want.right_sum)),
                                         longint'(i_right_sum));
                    bad |= field_differs("left_peak", longint'(want.left_peak),
                                         longint'(i_left_peak));
                    bad |= field_differs("right_peak", longint'(want.right_peak),
                                         longint'(i_right_peak));
                    bad |= field_differs("equal_count", longint'(want.equal_cnt),
                                         longint'(i_equal_count));
                    if (bad) begin
                        fail_cnt++;
                    end
                    checked_cnt++;
                end
            end
            if (i_req_valid && !i_req_stall) begin
                measure_frame(i_left_sample, i_right_sample);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= totals_q.size();
        o_checked    <= checked_cnt;
    end

endmodule

// ----- test/testbench.sv -----
// Top of the level meter testbench: clock, reset, frame stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_FRAMES = 1530;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [slmcc_pkg::CNT_W-1:0] LEN_MAX = {slmcc_pkg::CNT_W{1'b1}};
    localparam logic signed [slmcc_pkg::IN_W-1:0] S_MIN =
        {1'b1, {(slmcc_pkg::IN_W-1){1'b0}}};
    localparam logic signed [slmcc_pkg::IN_W-1:0] S_MAX =
        {1'b0, {(slmcc_pkg::IN_W-1){1'b1}}};

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [slmcc_pkg::CNT_W-1:0]         cfg_data = '0;
    logic                                req_valid = 1'b0;
    logic                                req_stall;
    logic signed [slmcc_pkg::IN_W-1:0]   left_in = '0;
    logic signed [slmcc_pkg::IN_W-1:0]   right_in = '0;
    logic                                res_valid;
    logic                                res_stall = 1'b0;
    logic [slmcc_pkg::SQ_W-1:0]          left_square_sum, right_square_sum;
    logic signed [slmcc_pkg::SUM_W-1:0]  left_sum, right_sum;
    logic [slmcc_pkg::PEAK_W-1:0]        left_peak, right_peak;
    logic [slmcc_pkg::CNT_W-1:0]         equal_count;

    int tx_idle_pct = 24;
    int rx_idle_pct = 45;
    int cycles = 0;
    int frames_sent = 0;
    int len_writes = 0;
    int fail_count, pending, checked;

    stereo_level_meter_copy_check i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_valid            (req_valid),
        .o_stall            (req_stall),
        .i_left_sample      (left_in),
        .i_right_sample     (right_in),
        .o_valid            (res_valid),
        .i_stall            (res_stall),
        .o_left_square_sum  (left_square_sum),
        .o_right_square_sum (right_square_sum),
        .o_left_sum         (left_sum),
        .o_right_sum        (right_sum),
        .o_left_peak        (left_peak),
        .o_right_peak       (right_peak),
        .o_equal_count      (equal_count)
    );

    level_meter_checker u_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_req_valid        (req_valid),
        .i_req_stall        (req_stall),
        .i_left_sample      (left_in),
        .i_right_sample     (right_in),
        .i_res_valid        (res_valid),
        .i_res_stall        (res_stall),
        .i_left_square_sum  (left_square_sum),
        .i_right_square_sum (right_square_sum),
        .i_left_sum         (left_sum),
        .i_right_sum        (right_sum),
        .i_left_peak        (left_peak),
        .i_right_peak       (right_peak),
        .i_equal_count      (equal_count),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        res_stall = ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Offer one frame and hold it until accepted; valid stays high for the next call.
    task automatic send_frame(input logic signed [slmcc_pkg::IN_W-1:0] l,
                              input logic signed [slmcc_pkg::IN_W-1:0] r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        left_in   = l;
        right_in  = r;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
        frames_sent++;
    endtask

    // Drop valid, wait for every pending result, then let the pipeline empty.
    task automatic settle_idle();
        req_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_len(input logic [slmcc_pkg::CNT_W-1:0] len);
        settle_idle();
        cfg_we   = 1'b1;
        cfg_data = len;
        @(negedge clk);
        cfg_we = 1'b0;
        len_writes++;
    endtask

    function automatic logic signed [slmcc_pkg::IN_W-1:0] edge_sample();
        case ($urandom_range(0, 3))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic void rand_frame(output logic signed [slmcc_pkg::IN_W-1:0] l,
                                       output logic signed [slmcc_pkg::IN_W-1:0] r);
        case ($urandom_range(0, 9))
            0: begin
                l = edge_sample();
                r = edge_sample();
            end
            1, 2, 3: begin
                l = slmcc_pkg::IN_W'($urandom);
                r = l;
            end
            4: begin
                l = slmcc_pkg::IN_W'(int'($urandom_range(0, 8)) - 4);
                r = slmcc_pkg::IN_W'(int'($urandom_range(0, 8)) - 4);
            end
            default: begin
                l = slmcc_pkg::IN_W'($urandom);
                r = slmcc_pkg::IN_W'($urandom);
            end
        endcase
    endfunction

    initial begin
        int                                rand_start;
        int                                done;
        int                                n;
        logic [slmcc_pkg::CNT_W-1:0]       len;
        logic signed [slmcc_pkg::IN_W-1:0] l, r;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset length: these frames only accumulate
        send_frame('0, '0);
        send_frame(S_MIN, S_MIN);
        send_frame(S_MAX, S_MIN);
        send_frame('1, 16'sd1);
        // shorten mid-run: the next frame closes the long run
        write_len(slmcc_pkg::CNT_W'(1));
        send_frame(S_MAX, S_MAX);
        send_frame(S_MIN, '0);
        send_frame('0, S_MIN);
        send_frame(16'sd1, '1);
        send_frame('1, '1);
        // zero length behaves as one
        write_len('0);
        send_frame(S_MIN, S_MAX);
        send_frame(16'sd12345, 16'sd12345);
        send_frame(-16'sd2, 16'sd3);
        write_len(LEN_MAX);
        send_frame(S_MIN, S_MIN);
        send_frame(S_MIN, S_MIN);
        send_frame(S_MAX, S_MAX);
        send_frame(16'sd100, -16'sd100);
        write_len(slmcc_pkg::CNT_W'(3));
        send_frame(16'sd7, 16'sd7);
        send_frame('0, 16'sd1);
        send_frame(16'sd2, 16'sd2);
        send_frame(-16'sd3, -16'sd3);

        rand_start = frames_sent;
        while (frames_sent - rand_start < RANDOM_FRAMES) begin
            done = frames_sent - rand_start;
            if (done < RANDOM_FRAMES / 3) begin
                tx_idle_pct = 24;
                rx_idle_pct = 45;
            end else if (done < 2 * RANDOM_FRAMES / 3) begin
                tx_idle_pct = 45;
                rx_idle_pct = 24;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(0, 15))
                0: len = '0;
                1: len = slmcc_pkg::CNT_W'(1);
                2: len = LEN_MAX;
                3: len = slmcc_pkg::CNT_W'(2);
                default: len = slmcc_pkg::CNT_W'($urandom_range(2, 40));
            endcase
            write_len(len);
            n = (len == LEN_MAX) ? $urandom_range(1, 12) : $urandom_range(8, 80);
            repeat (n) begin
                rand_frame(l, r);
                send_frame(l, r);
            end
        end

        settle_idle();
        $display("Level meter run: %0d frames under %0d frame-count settings,",
                 frames_sent, len_writes);
        $display("  %0d measurement results compared field by field", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
